FILE: src/stereo_eq_cascade_soft_limiter_unit_macros.svh
// ----------------------------------------------------------------------------
// stereo eq cascade soft limiter unit: assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef STEREO_EQ_CASCADE_SOFT_LIMITER_UNIT_MACROS_SVH
`define STEREO_EQ_CASCADE_SOFT_LIMITER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SQEQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sqeq: property failed");

// next-cycle implication, sampled on clk, off during rst
`define SQEQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sqeq: property failed");

`endif

FILE: src/sqeq_pkg.sv
// ----------------------------------------------------------------------------
// sqeq_pkg
// types, constants and helper functions of the stereo eq / soft limiter
// ----------------------------------------------------------------------------
`default_nettype none

package sqeq_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_W      = 32;
  localparam int MUL_A_W     = 32;
  localparam int MUL_B_W     = SAMPLE_BITS + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int ACC_W       = PROD_W + 3;
  localparam int SAT_W       = 48;
  localparam int PAW         = 5;

  localparam int NUM_MANUAL_DEF = 8;
  localparam int NUM_AUTO_DEF   = 8;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh1000_0000;

  localparam logic signed [SAT_W-1:0] SAT_HI = (48'sd1 <<< (SAMPLE_BITS - 1)) - 48'sd1;
  localparam logic signed [SAT_W-1:0] SAT_LO = -(48'sd1 <<< (SAMPLE_BITS - 1));

  // item op codes
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_COEF  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MANUAL_STAGES = 3'd0;
  localparam logic [2:0] REG_AUTO_ON       = 3'd1;
  localparam logic [2:0] REG_AUTO_STAGES   = 3'd2;
  localparam logic [2:0] REG_PREAMP_GAIN   = 3'd3;
  localparam logic [2:0] REG_LIMITER_ON    = 3'd4;
  localparam logic [2:0] REG_LIMITER_THR   = 3'd5;
  localparam logic [2:0] REG_LIMITER_HR    = 3'd6;
  localparam logic [2:0] REG_LIMITER_INVHR = 3'd7;

  localparam logic [23:0] PREAMP_GAIN_RST = 24'd1048576;
  localparam logic [22:0] LIMITER_THR_RST = 23'd7549747;
  localparam logic [22:0] LIMITER_HR_RST  = 23'd838861;
  localparam logic [23:0] LIMITER_INV_RST = 24'd655360;

  // exp(-k/32) table, Q1.24
  localparam int EXP_ENTRIES = 512;
  localparam int EXP_IDX_W   = 9;
  localparam logic [63:0] EXP_STEP_R = 64'd1040706261;
  localparam logic [24:0] EXP_ONE = 25'd16777216;

  typedef logic [24:0] exp_tab_t [EXP_ENTRIES];

  function automatic exp_tab_t build_exp();
    exp_tab_t t;
    logic [63:0] e;
    e = 64'd1 << 24;
    for (int k = 0; k < EXP_ENTRIES; k++) begin
      t[k] = e[24:0];
      e = (e * EXP_STEP_R + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp();

  // shared multiply-accumulate control
  typedef struct packed {
    logic clr;
    logic mul_en;
    logic sub;
  } mac_ctl_t;

  function automatic sample_t sat_s(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    else if (v < SAT_LO) r = SAT_LO;
    return r[SAMPLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/sqeq_if.sv
// ----------------------------------------------------------------------------
// sqeq item channels
// input channel (ops and stereo frames) and result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface sqeq_in_if
  import sqeq_pkg::*;
;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  sample_t     left_in;
  sample_t     right_in;
  logic [3:0]  stage_sel;
  logic [2:0]  coeff_sel;
  logic signed [COEF_W-1:0] coeff_value;

  modport source (output valid, op, left_in, right_in, stage_sel, coeff_sel, coeff_value,
                  input ready);
  modport sink   (input valid, op, left_in, right_in, stage_sel, coeff_sel, coeff_value,
                  output ready);
endinterface

interface sqeq_out_if
  import sqeq_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

FILE: src/sqeq_mac.sv
// ----------------------------------------------------------------------------
// sqeq_mac
// shared multiplier with product register and accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module sqeq_mac
  import sqeq_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mac_ctl_t                  ctl,
  input  wire logic signed [MUL_A_W-1:0] a,
  input  wire logic signed [MUL_B_W-1:0] b,
  output logic signed [ACC_W-1:0]        acc,
  output logic                           busy
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_v;
  logic                     prod_sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.mul_en;
    end
    prod_sub <= ctl.sub;
    if (ctl.mul_en) begin
      prod <= a * b;
    end
    if (ctl.clr) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= prod_sub ? acc - ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  assign busy = prod_v;

endmodule

`default_nettype wire

FILE: src/stereo_eq_cascade_soft_limiter_unit.sv
// ----------------------------------------------------------------------------
// stereo_eq_cascade_soft_limiter_unit
// stereo biquad cascade (manual, preamp, auto) with table-based soft limiter
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  items     in   valid/ready      op, left_in, right_in, stage_sel, coeff_sel,
//                                  coeff_value
//  results   out  valid/ready      left_out, right_out
//  apb       in   psel/penable     paddr, pwdata, prdata (pready tied high)
//
// a frame runs left then right through one shared multiply-accumulate unit:
// per channel the active stages of all 16 biquads (manual, then preamp and
// auto when auto is on), then the limiter when it is on. coefficient writes
// and clears leave the unit idle. ready is low while a frame is in work; a
// finished result waits in the output register and the next item is taken
// meanwhile. rst is synchronous; coefficient and delay stores read as reset
// values through per-entry valid bits, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_eq_cascade_soft_limiter_unit
  import sqeq_pkg::*;
#(
  parameter int NUM_MANUAL = NUM_MANUAL_DEF,
  parameter int NUM_AUTO   = NUM_AUTO_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  sqeq_in_if.sink             items,
  sqeq_out_if.source          results,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [PAW-1:0] paddr,
  input  wire logic [31:0]    pwdata,
  output logic      [31:0]    prdata,
  output logic                pready
);

  localparam int NUM_STAGES = NUM_MANUAL + NUM_AUTO;
  localparam int NUM_MAX    = (NUM_MANUAL > NUM_AUTO) ? NUM_MANUAL : NUM_AUTO;
  localparam int SW         = $clog2(NUM_MAX + 1);
  localparam int CDEPTH     = NUM_STAGES * 5;
  localparam int DDEPTH     = NUM_STAGES * 8;
  localparam int CAW        = $clog2(CDEPTH);
  localparam int DAW        = $clog2(DDEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_NEXT, S_TAP, S_DRAIN, S_ROUND, S_WB, S_PRE_MUL, S_PRE_WAIT,
    S_PRE_RND, S_LIM_ABS, S_LIM_M1, S_LIM_W1, S_LIM_K, S_LIM_ROM, S_LIM_W2,
    S_LIM_FIN
  } state_t;

  typedef enum logic [2:0] {
    PH_MAN, PH_PRE, PH_AUTO, PH_LIM, PH_END
  } phase_t;

  // configuration registers
  logic [3:0]  manual_stages;
  logic        auto_on;
  logic [3:0]  auto_stages;
  logic [23:0] preamp_gain;
  logic        limiter_on;
  logic [22:0] limiter_threshold;
  logic [22:0] limiter_headroom;
  logic [23:0] limiter_inv_headroom;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      manual_stages        <= '0;
      auto_on              <= 1'b0;
      auto_stages          <= '0;
      preamp_gain          <= PREAMP_GAIN_RST;
      limiter_on           <= 1'b0;
      limiter_threshold    <= LIMITER_THR_RST;
      limiter_headroom     <= LIMITER_HR_RST;
      limiter_inv_headroom <= LIMITER_INV_RST;
    end else if (cfg_wr) begin
      case (paddr[PAW-1:2])
        REG_MANUAL_STAGES: manual_stages        <= pwdata[3:0];
        REG_AUTO_ON:       auto_on              <= pwdata[0];
        REG_AUTO_STAGES:   auto_stages          <= pwdata[3:0];
        REG_PREAMP_GAIN:   preamp_gain          <= pwdata[23:0];
        REG_LIMITER_ON:    limiter_on           <= pwdata[0];
        REG_LIMITER_THR:   limiter_threshold    <= pwdata[22:0];
        REG_LIMITER_HR:    limiter_headroom     <= pwdata[22:0];
        REG_LIMITER_INVHR: limiter_inv_headroom <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PAW-1:2])
      REG_MANUAL_STAGES: prdata = 32'(manual_stages);
      REG_AUTO_ON:       prdata = 32'(auto_on);
      REG_AUTO_STAGES:   prdata = 32'(auto_stages);
      REG_PREAMP_GAIN:   prdata = 32'(preamp_gain);
      REG_LIMITER_ON:    prdata = 32'(limiter_on);
      REG_LIMITER_THR:   prdata = 32'(limiter_threshold);
      REG_LIMITER_HR:    prdata = 32'(limiter_headroom);
      REG_LIMITER_INVHR: prdata = 32'(limiter_inv_headroom);
      default:           prdata = '0;
    endcase
  end

  // sequencer state
  state_t  state;
  phase_t  phase;
  logic [SW-1:0] st;
  logic          ch;
  logic [2:0]    k;
  logic [1:0]    j;
  sample_t       x;
  sample_t       in_r;
  sample_t       lres;
  sample_t       ybuf;
  sample_t       old_d0;
  sample_t       old_d2;
  logic [SAMPLE_BITS-1:0] ovr;
  logic          rd_v;
  logic [2:0]    rd_k;
  logic          kbig;
  logic          out_v;
  sample_t       lout;
  sample_t       rout;

  logic accept;
  assign accept = items.valid && items.ready;
  assign items.ready   = (state == S_IDLE);
  assign results.valid = out_v;
  assign results.left_out  = lout;
  assign results.right_out = rout;

  // right channel done and the output register free
  logic out_load;
  assign out_load = (state == S_NEXT) && (phase == PH_END) && ch &&
                    (!out_v || results.ready);

  // clamped stage counts
  logic [SW-1:0] nman, naut;
  always_comb begin
    if ({2'b0, manual_stages} > 6'(NUM_MANUAL)) nman = SW'(NUM_MANUAL);
    else nman = SW'(manual_stages);
    if ({2'b0, auto_stages} > 6'(NUM_AUTO)) naut = SW'(NUM_AUTO);
    else naut = SW'(auto_stages);
  end

  // store addressing
  logic [5:0] gl;
  logic [8:0] clin, dlin, wblin;
  logic [CAW-1:0] craddr;
  logic [DAW-1:0] draddr, dwaddr;
  always_comb begin
    gl     = (phase == PH_AUTO) ? 6'(NUM_MANUAL) + 6'(st) : 6'(st);
    clin   = 9'(gl) * 9'd5 + 9'(k);
    dlin   = {gl, ch, 2'(k - 3'd1)};
    wblin  = {gl, ch, j};
    craddr = clin[CAW-1:0];
    draddr = dlin[DAW-1:0];
    dwaddr = wblin[DAW-1:0];
  end

  // coefficient write target
  logic [5:0] wg;
  logic       wok;
  logic [8:0] wlin;
  logic [CAW-1:0] cwaddr;
  always_comb begin
    if (!items.stage_sel[3]) begin
      wg  = {2'b0, items.stage_sel};
      wok = wg < 6'(NUM_MANUAL);
    end else begin
      wg  = 6'(NUM_MANUAL) + {3'b0, items.stage_sel[2:0]};
      wok = {3'b0, items.stage_sel[2:0]} < 6'(NUM_AUTO);
    end
    wok    = wok && (items.coeff_sel <= 3'd4);
    wlin   = 9'(wg) * 9'd5 + 9'(items.coeff_sel);
    cwaddr = wlin[CAW-1:0];
  end

  logic coef_we;
  assign coef_we = accept && (items.op == OP_COEF) && wok;

  // coefficient store
  logic signed [COEF_W-1:0] coef_mem [CDEPTH];
  logic [CDEPTH-1:0]        coef_vld;
  logic signed [COEF_W-1:0] cq;
  logic                     cq_v;

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[cwaddr] <= items.coeff_value;
    end
    cq <= coef_mem[craddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      cq_v     <= 1'b0;
    end else begin
      if (coef_we) coef_vld[cwaddr] <= 1'b1;
      cq_v <= coef_vld[craddr];
    end
  end

  // delay store
  sample_t            dly_mem [DDEPTH];
  logic [DDEPTH-1:0]  dly_vld;
  sample_t            dq;
  logic               dq_v;
  sample_t            wb_data;

  always_comb begin
    case (j)
      2'd0:    wb_data = x;
      2'd1:    wb_data = old_d0;
      2'd2:    wb_data = ybuf;
      default: wb_data = old_d2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_WB) begin
      dly_mem[dwaddr] <= wb_data;
    end
    dq <= dly_mem[draddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dly_vld <= '0;
      dq_v    <= 1'b0;
    end else begin
      if (accept && (items.op == OP_CLEAR)) dly_vld <= '0;
      else if (state == S_WB) dly_vld[dwaddr] <= 1'b1;
      dq_v <= dly_vld[draddr];
    end
  end

  // exp table read
  logic signed [ACC_W-1:0] acc;
  logic [24:0] rom_q;
  logic signed [ACC_W-1:0] kf;
  assign kf = (acc + (ACC_W'(1) << 33)) >>> 34;
  always_ff @(posedge clk) begin
    rom_q <= EXP_TAB[kf[EXP_IDX_W-1:0]];
  end

  // shared multiply-accumulate
  mac_ctl_t                  mctl;
  logic signed [MUL_A_W-1:0] ma;
  logic signed [MUL_B_W-1:0] mb;
  logic                      mbusy;
  logic signed [COEF_W-1:0]  coef_eff;
  sample_t                   d_eff;
  logic [24:0]               e_eff;

  always_comb begin
    coef_eff = cq_v ? cq : ((rd_k == 3'd0) ? COEF_ONE : '0);
    d_eff    = dq_v ? dq : '0;
    e_eff    = kbig ? '0 : rom_q;
    mctl     = '0;
    ma       = '0;
    mb       = '0;
    if (rd_v) begin
      mctl.mul_en = 1'b1;
      mctl.sub    = (rd_k >= 3'd3);
      ma          = coef_eff;
      mb          = (rd_k == 3'd0) ? MUL_B_W'(x) : MUL_B_W'(d_eff);
    end
    case (state)
      S_NEXT: mctl.clr = 1'b1;
      S_PRE_MUL: begin
        mctl.mul_en = 1'b1;
        ma          = MUL_A_W'(preamp_gain);
        mb          = MUL_B_W'(x);
      end
      S_LIM_M1: begin
        mctl.mul_en = 1'b1;
        ma          = MUL_A_W'(limiter_inv_headroom);
        mb          = MUL_B_W'(ovr);
      end
      S_LIM_ROM: begin
        mctl.clr    = 1'b1;
        mctl.mul_en = 1'b1;
        ma          = MUL_A_W'(EXP_ONE - e_eff);
        mb          = MUL_B_W'(limiter_headroom);
      end
      default: ;
    endcase
  end

  sqeq_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mctl),
    .a    (ma),
    .b    (mb),
    .acc  (acc),
    .busy (mbusy)
  );

  // rounding and limiter arithmetic
  logic signed [ACC_W-1:0] bq_sh, pre_sh, hr_sh;
  logic signed [SAMPLE_BITS:0] xs, ax;
  logic [SAMPLE_BITS+1:0] comp;
  logic signed [SAT_W-1:0] lim_v;
  always_comb begin
    bq_sh  = (acc + (ACC_W'(1) << 27)) >>> 28;
    pre_sh = (acc + (ACC_W'(1) << 19)) >>> 20;
    hr_sh  = (acc + (ACC_W'(1) << 23)) >>> 24;
    xs     = (SAMPLE_BITS + 1)'(x);
    ax     = xs[SAMPLE_BITS] ? -xs : xs;
    comp   = (SAMPLE_BITS + 2)'(limiter_threshold) + hr_sh[SAMPLE_BITS+1:0];
    lim_v  = x[SAMPLE_BITS-1] ? -$signed(SAT_W'(comp)) : $signed(SAT_W'(comp));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_MAN;
      rd_v  <= 1'b0;
      out_v <= 1'b0;
      st    <= '0;
      ch    <= 1'b0;
      k     <= '0;
      j     <= '0;
    end else begin
      rd_v <= (state == S_TAP);
      rd_k <= k;
      if (out_load) out_v <= 1'b1;
      else if (out_v && results.ready) out_v <= 1'b0;
      if (rd_v && (rd_k == 3'd1)) old_d0 <= d_eff;
      if (rd_v && (rd_k == 3'd3)) old_d2 <= d_eff;
      case (state)
        S_IDLE: begin
          if (accept && (items.op == OP_FRAME)) begin
            x     <= items.left_in;
            in_r  <= items.right_in;
            ch    <= 1'b0;
            st    <= '0;
            phase <= PH_MAN;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          case (phase)
            PH_MAN: begin
              if (st < nman) begin
                k     <= '0;
                state <= S_TAP;
              end else begin
                phase <= PH_PRE;
              end
            end
            PH_PRE: begin
              if (auto_on) state <= S_PRE_MUL;
              else phase <= PH_LIM;
            end
            PH_AUTO: begin
              if (st < naut) begin
                k     <= '0;
                state <= S_TAP;
              end else begin
                phase <= PH_LIM;
              end
            end
            PH_LIM: begin
              if (limiter_on) state <= S_LIM_ABS;
              else phase <= PH_END;
            end
            default: begin
              if (!ch) begin
                lres  <= x;
                x     <= in_r;
                ch    <= 1'b1;
                st    <= '0;
                phase <= PH_MAN;
              end else if (!out_v || results.ready) begin
                lout  <= lres;
                rout  <= x;
                state <= S_IDLE;
              end
            end
          endcase
        end
        S_TAP: begin
          k <= k + 3'd1;
          if (k == 3'd4) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!rd_v && !mbusy) state <= S_ROUND;
        end
        S_ROUND: begin
          ybuf  <= sat_s(bq_sh[SAT_W-1:0]);
          j     <= '0;
          state <= S_WB;
        end
        S_WB: begin
          j <= j + 2'd1;
          if (j == 2'd3) begin
            x     <= ybuf;
            st    <= st + 1'b1;
            state <= S_NEXT;
          end
        end
        S_PRE_MUL:  state <= S_PRE_WAIT;
        S_PRE_WAIT: state <= S_PRE_RND;
        S_PRE_RND: begin
          x     <= sat_s(pre_sh[SAT_W-1:0]);
          phase <= PH_AUTO;
          st    <= '0;
          state <= S_NEXT;
        end
        S_LIM_ABS: begin
          // at or below the knee the sample passes unchanged
          if (ax <= (SAMPLE_BITS + 1)'(limiter_threshold)) begin
            phase <= PH_END;
            state <= S_NEXT;
          end else begin
            ovr   <= SAMPLE_BITS'(ax - (SAMPLE_BITS + 1)'(limiter_threshold));
            state <= S_LIM_M1;
          end
        end
        S_LIM_M1: state <= S_LIM_W1;
        S_LIM_W1: state <= S_LIM_K;
        S_LIM_K: begin
          kbig  <= |kf[ACC_W-1:EXP_IDX_W];
          state <= S_LIM_ROM;
        end
        S_LIM_ROM: state <= S_LIM_W2;
        S_LIM_W2:  state <= S_LIM_FIN;
        S_LIM_FIN: begin
          x     <= sat_s(lim_v);
          phase <= PH_END;
          state <= S_NEXT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/sqeq_chk.sv
// ----------------------------------------------------------------------------
// sqeq_chk
// port-level checks on the stereo eq unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_eq_cascade_soft_limiter_unit_macros.svh"

module sqeq_chk
  import sqeq_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_op,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire sample_t    left_out,
  input wire sample_t    right_out
);

  // a stalled result holds
  `SQEQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(left_out) && $stable(right_out))

  // writes and clears never make a result
  `SQEQ_ASSERT_NXT(a_no_spurious, in_valid && in_ready && (in_op != OP_FRAME) && !out_valid,
    !out_valid)

  // a frame item keeps the unit busy
  `SQEQ_ASSERT_NXT(a_frame_busy, in_valid && in_ready && (in_op == OP_FRAME), !in_ready)

  // a result appears only at the end of a frame
  `SQEQ_ASSERT_IMP(a_out_from_work, $rose(out_valid), $past(!in_ready))

endmodule

bind stereo_eq_cascade_soft_limiter_unit sqeq_chk u_sqeq_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_op     (items.op),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .left_out  (results.left_out),
  .right_out (results.right_out)
);

`default_nettype wire
